// File: design/sbf_pkg.sv
// Shared constants, field layout, codes and control/status types for the sample ring fit.
`default_nettype none

package sbf_pkg;

    // Ring depth default and fit order
    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int HALF_DEGREE      = 2;
    localparam int TAP_COUNT        = HALF_DEGREE + 1;
    localparam int CONTROL_COUNT    = 2 * HALF_DEGREE + 1;
    localparam int WEIGHT_COUNT     = CONTROL_COUNT * TAP_COUNT;

    // Counter widths
    localparam int TAP_W  = $clog2(TAP_COUNT);
    localparam int WPTR_W = $clog2(WEIGHT_COUNT);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 32;
    localparam int WIDX_W   = 4;
    localparam int WVAL_W   = 32;
    localparam int CTRL_W   = 3;
    localparam int STRIDE_W = 5;
    localparam int THR_W    = 32;

    // Stream packing
    localparam int X_LSB       = 0;
    localparam int Y_LSB       = X_LSB + COORD_W;
    localparam int WIDX_LSB    = Y_LSB + COORD_W;
    localparam int WVAL_LSB    = WIDX_LSB + WIDX_W;
    localparam int IN_BITS     = WVAL_LSB + WVAL_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * COORD_W;

    // Arithmetic
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int FRAC_SHIFT = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;
    localparam logic [STRIDE_W-1:0]  STRIDE_RESET = 5'd1;
    localparam logic [THR_W-1:0]     THRESH_RESET = 32'd4294967;

    localparam logic [1:0] STILL_MAX = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_PRED = 2'd1,
        FUNC_WGT  = 2'd2
    } func_t;

    typedef struct packed {
        logic load_in;
        logic first;
        logic rd_newest;
        logic sq;
        logic upd;
        logic wr_one;
        logic fill;
        logic wr_weight;
        logic pred_start;
        logic tap_rd;
        logic tap_ld;
        logic mul;
        logic acc;
        logic out_load;
        logic next_ctrl;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic still;
        logic sweep_last;
        logic tap_done;
        logic tap_last;
        logic ctrl_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: design/sbf_dp.sv
// Datapath: sample ring memory, stillness test, tap gather, multiply-accumulate and result register.
`default_nettype none

module sbf_dp #(
    parameter int BUFFER_DEPTH = sbf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [sbf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [sbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire sbf_pkg::cmd_t                     cmd,
    output sbf_pkg::sts_t                          sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sbf_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [sbf_pkg::CTRL_W-1:0]             m_tuser,
    output logic                                   m_tlast
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int AW1   = AW + 1;
    localparam int CW    = sbf_pkg::COORD_W;
    localparam int SW    = sbf_pkg::STRIDE_W;
    localparam int TW    = sbf_pkg::TAP_W;
    localparam int PW    = sbf_pkg::WPTR_W;
    localparam int KW    = sbf_pkg::CTRL_W;
    localparam int PRW   = sbf_pkg::PROD_W;
    localparam int AC    = sbf_pkg::ACC_W;
    localparam int NTAP  = sbf_pkg::TAP_COUNT;
    localparam int NWGT  = sbf_pkg::WEIGHT_COUNT;

    // Configuration
    logic [SW-1:0]               stride_reg;
    logic [sbf_pkg::THR_W-1:0]   thr_reg;

    // Ring control
    logic [AW-1:0]   newest_reg;
    logic            empty_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [AW-1:0]   sweep_reg;
    logic [AW-1:0]   newest_next;

    // Ring memory, {y, x} per slot
    logic [2*CW-1:0] ring_mem [BUFFER_DEPTH];
    logic [2*CW-1:0] rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    // Enqueue path
    logic signed [CW-1:0] in_x_reg;
    logic signed [CW-1:0] in_y_reg;
    logic signed [CW:0]   diff_x;
    logic signed [CW:0]   diff_y;
    logic [CW:0]          mag_x;
    logic [CW:0]          mag_y;
    logic                 far_reg;
    logic [31:0]          sq_x_reg;
    logic [31:0]          sq_y_reg;
    logic [32:0]          dist_sum;
    logic                 moved;

    // Tap gather
    logic [SW-1:0]        rem;
    logic [AW-1:0]        s_mod;
    logic [AW-1:0]        tap_slot_reg;
    logic [AW-1:0]        slot_prev;
    logic [AW:0]          slot_wrap;
    logic [TW-1:0]        tap_cnt_reg;
    logic signed [CW-1:0] tap_x_reg [NTAP];
    logic signed [CW-1:0] tap_y_reg [NTAP];

    // Fit
    logic signed [sbf_pkg::WVAL_W-1:0] wt_reg [NWGT];
    logic [sbf_pkg::WIDX_W-1:0]        widx;
    logic [PW-1:0]                     wptr_reg;
    logic [TW-1:0]                     tap_i_reg;
    logic [KW-1:0]                     ctrl_reg;
    logic signed [PRW-1:0]             prod_x_reg;
    logic signed [PRW-1:0]             prod_y_reg;
    logic signed [AC-1:0]              acc_x_reg;
    logic signed [AC-1:0]              acc_y_reg;
    logic signed [AC-1:0]              acc_x_base;
    logic signed [AC-1:0]              acc_y_base;

    // Result register
    logic            m_valid_reg;
    logic [CW-1:0]   m_x_reg;
    logic [CW-1:0]   m_y_reg;
    logic [KW-1:0]   m_idx_reg;
    logic            m_last_reg;

    function automatic logic [CW-1:0] sat_shift(input logic signed [AC-1:0] a);
        logic signed [AC-1:0] s;
        logic [CW-1:0]        r;
        s = a >>> sbf_pkg::FRAC_SHIFT;
        if (!s[AC-1] && (|s[AC-2:CW-1]))
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        else if (s[AC-1] && !(&s[AC-2:CW-1]))
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = s[CW-1:0];
        end
        return r;
    endfunction

    assign widx = s_tdata[sbf_pkg::WIDX_LSB +: sbf_pkg::WIDX_W];

    // Stillness test
    always_comb
    begin
        diff_x = {rd_data_reg[CW-1], rd_data_reg[CW-1:0]} - {in_x_reg[CW-1], in_x_reg};
        diff_y = {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]} - {in_y_reg[CW-1], in_y_reg};
        mag_x  = diff_x[CW] ? 33'(-diff_x) : 33'(diff_x);
        mag_y  = diff_y[CW] ? 33'(-diff_y) : 33'(diff_y);
        dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        moved  = far_reg || (dist_sum > {1'b0, thr_reg});
        if (moved)
        begin
            count_next = 2'd0;
        end
        else if (count_reg == sbf_pkg::STILL_MAX)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + 2'd1;
        end
        newest_next = (newest_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : newest_reg + 1'b1;
    end

    // Stride reduced modulo the ring depth, then one step back per tap
    always_comb
    begin
        rem = stride_reg;
        for (int j = SW - 1; j >= 0; j--)
        begin
            if (32'(rem) >= (32'(BUFFER_DEPTH) << j))
            begin
                rem = rem - SW'(32'(BUFFER_DEPTH) << j);
            end
        end
        s_mod     = AW'(rem);
        slot_wrap = {1'b0, tap_slot_reg} + AW1'(BUFFER_DEPTH) - {1'b0, s_mod};
        slot_prev = (tap_slot_reg >= s_mod) ? tap_slot_reg - s_mod : slot_wrap[AW-1:0];
    end

    always_comb
    begin
        mem_we     = cmd.fill | cmd.wr_one;
        mem_waddr  = cmd.fill ? sweep_reg : newest_reg;
        mem_re     = cmd.rd_newest | cmd.tap_rd;
        mem_raddr  = cmd.tap_rd ? tap_slot_reg : newest_reg;
        acc_x_base = (tap_i_reg == '0) ? '0 : acc_x_reg;
        acc_y_base = (tap_i_reg == '0) ? '0 : acc_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= {in_y_reg, in_x_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg   <= sbf_pkg::STRIDE_RESET;
            thr_reg      <= sbf_pkg::THRESH_RESET;
            newest_reg   <= '0;
            empty_reg    <= 1'b1;
            count_reg    <= 2'd0;
            sweep_reg    <= '0;
            tap_slot_reg <= '0;
            tap_cnt_reg  <= '0;
            tap_i_reg    <= '0;
            wptr_reg     <= '0;
            ctrl_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sbf_pkg::CFG_STRIDE: stride_reg <= cfg_data[SW-1:0];
                    sbf_pkg::CFG_THRESH: thr_reg    <= cfg_data[sbf_pkg::THR_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.first)
            begin
                newest_reg <= '0;
                empty_reg  <= 1'b0;
                count_reg  <= sbf_pkg::STILL_MAX;
                sweep_reg  <= '0;
            end
            if (cmd.upd)
            begin
                newest_reg <= newest_next;
                count_reg  <= count_next;
                sweep_reg  <= '0;
            end
            if (cmd.fill)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.pred_start)
            begin
                tap_slot_reg <= newest_reg;
                tap_cnt_reg  <= TW'(sbf_pkg::HALF_DEGREE);
                tap_i_reg    <= '0;
                wptr_reg     <= '0;
                ctrl_reg     <= '0;
            end
            if (cmd.tap_ld)
            begin
                tap_slot_reg <= slot_prev;
                tap_cnt_reg  <= tap_cnt_reg - 1'b1;
            end
            if (cmd.acc)
            begin
                wptr_reg  <= wptr_reg + 1'b1;
                tap_i_reg <= sts.tap_last ? '0 : tap_i_reg + 1'b1;
            end
            if (cmd.next_ctrl)
            begin
                ctrl_reg <= ctrl_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_x_reg <= s_tdata[sbf_pkg::X_LSB +: CW];
            in_y_reg <= s_tdata[sbf_pkg::Y_LSB +: CW];
        end
        if (cmd.wr_weight && (widx < sbf_pkg::WIDX_W'(NWGT)))
        begin
            wt_reg[widx[PW-1:0]] <= s_tdata[sbf_pkg::WVAL_LSB +: sbf_pkg::WVAL_W];
        end
        if (cmd.sq)
        begin
            far_reg  <= (|mag_x[CW:16]) || (|mag_y[CW:16]);
            sq_x_reg <= mag_x[15:0] * mag_x[15:0];
            sq_y_reg <= mag_y[15:0] * mag_y[15:0];
        end
        if (cmd.tap_ld)
        begin
            // An untouched ring reads as zero
            tap_x_reg[tap_cnt_reg] <= empty_reg ? '0 : rd_data_reg[CW-1:0];
            tap_y_reg[tap_cnt_reg] <= empty_reg ? '0 : rd_data_reg[2*CW-1:CW];
        end
        if (cmd.mul)
        begin
            prod_x_reg <= wt_reg[wptr_reg] * tap_x_reg[tap_i_reg];
            prod_y_reg <= wt_reg[wptr_reg] * tap_y_reg[tap_i_reg];
        end
        if (cmd.acc)
        begin
            acc_x_reg <= acc_x_base + {{(AC-PRW){prod_x_reg[PRW-1]}}, prod_x_reg};
            acc_y_reg <= acc_y_base + {{(AC-PRW){prod_y_reg[PRW-1]}}, prod_y_reg};
        end
        if (cmd.out_load)
        begin
            m_x_reg    <= sat_shift(acc_x_reg);
            m_y_reg    <= sat_shift(acc_y_reg);
            m_idx_reg  <= ctrl_reg;
            m_last_reg <= sts.ctrl_last;
        end
    end

    always_comb
    begin
        sts.empty      = empty_reg;
        sts.still      = (count_next == sbf_pkg::STILL_MAX);
        sts.sweep_last = (sweep_reg == AW'(BUFFER_DEPTH - 1));
        sts.tap_done   = (tap_cnt_reg == '0);
        sts.tap_last   = (tap_i_reg == TW'(sbf_pkg::HALF_DEGREE));
        sts.ctrl_last  = (ctrl_reg == KW'(sbf_pkg::CONTROL_COUNT - 1));
        sts.out_free   = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: design/sbf_ctrl.sv
// Controller: sequences enqueue, ring flood, tap gather and the per-point multiply-accumulate.
`default_nettype none

module sbf_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic [sbf_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               s_tready,
    input  wire sbf_pkg::sts_t                 sts,
    output sbf_pkg::cmd_t                      cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_ENQ_SQ  = 11'b000_0000_0010,
        S_ENQ_UPD = 11'b000_0000_0100,
        S_WRITE   = 11'b000_0000_1000,
        S_FILL    = 11'b000_0001_0000,
        S_TAP_RD  = 11'b000_0010_0000,
        S_TAP_LD  = 11'b000_0100_0000,
        S_MUL     = 11'b000_1000_0000,
        S_ACC     = 11'b001_0000_0000,
        S_OUT     = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = accept;
                if (accept)
                begin
                    unique case (s_tuser)
                        sbf_pkg::FUNC_ENQ:
                        begin
                            if (sts.empty)
                            begin
                                cmd.first  = 1'b1;
                                state_next = S_FILL;
                            end
                            else
                            begin
                                cmd.rd_newest = 1'b1;
                                state_next    = S_ENQ_SQ;
                            end
                        end
                        sbf_pkg::FUNC_PRED:
                        begin
                            cmd.pred_start = 1'b1;
                            state_next     = S_TAP_RD;
                        end
                        sbf_pkg::FUNC_WGT:
                        begin
                            cmd.wr_weight = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_ENQ_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_ENQ_UPD;
            end
            S_ENQ_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = sts.still ? S_FILL : S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_one = 1'b1;
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TAP_RD:
            begin
                cmd.tap_rd = 1'b1;
                state_next = S_TAP_LD;
            end
            S_TAP_LD:
            begin
                cmd.tap_ld = 1'b1;
                state_next = sts.tap_done ? S_MUL : S_TAP_RD;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.tap_last ? S_OUT : S_MUL;
            end
            S_OUT:
            begin
                // Hold the finished point until the result register frees up
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.ctrl_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_ctrl = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/sample_ring_bezier_fit.sv
// Top level of the sample ring with fixed-weight Bezier control point fit.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser func; tdata x, y, w index, w
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser point index; tdata x, y; tlast
//  cfg       | in        | cfg_we (no wait)             | cfg_index, cfg_data
//
//  Enqueue reads the newest sample, squares the step, updates the stillness count and writes
//  one slot; when the count reaches 3 the ring is flooded instead, as for the first sample after reset.
//  Predict gathers the taps through the single ring read port and runs each control point
//  through the shared x/y multiplier pair, one tap per multiply-accumulate step.
//  A stalled result holds in the output register; the fit waits only when a further point is ready.
//  Reset needs no clearing pass: the ring reads as zero until the first sample floods it.
`default_nettype none

module sample_ring_bezier_fit #(
    parameter int BUFFER_DEPTH = sbf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // x_position, y_position, weight_index, weight_value, zero pad
    input  wire logic [sbf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  wire logic [sbf_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // control_x, control_y
    output logic [sbf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // control_index
    output logic [sbf_pkg::CTRL_W-1:0]             m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [sbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sbf_pkg::cmd_t cmd;
    sbf_pkg::sts_t sts;

    sbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tuser  (s_axis_tuser),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbf_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .m_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: design/sbf_chk.sv
// Port-level checker for the sample ring fit, bound to the top level.
`default_nettype none

module sbf_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [sbf_pkg::FUNC_W-1:0]        s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [sbf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [sbf_pkg::CTRL_W-1:0]        m_axis_tuser,
    input wire logic                              m_axis_tlast
);

    localparam logic [sbf_pkg::CTRL_W-1:0] LAST_IDX = sbf_pkg::CTRL_W'(sbf_pkg::CONTROL_COUNT - 1);

    // A predict request occupies the block for the following cycle
    a_pred_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sbf_pkg::FUNC_PRED))
        |=> !s_axis_tready)
        else $error("input ready while a predict is under way");

    // A weight write completes in its own cycle
    a_wgt_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sbf_pkg::FUNC_WGT))
        |=> s_axis_tready)
        else $error("weight write held the input");

    // The closing point of a fit carries the highest index, and only it
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_IDX)))
        else $error("tlast does not match the closing control point");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind sample_ring_bezier_fit sbf_chk u_sbf_chk (.*);

`default_nettype wire

// File: tb/sample_ring_bezier_fit_test.sv
// Self-checking stream testbench for the sample ring with fixed-weight Bezier fit.
`timescale 1ns / 1ps

module sample_ring_bezier_fit_test;
    import sbf_pkg::*;

    localparam int RING         = BUFFER_DEPTH_DEF;
    localparam int SLOT_W       = $clog2(RING);
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT        = 200000;
    localparam int PHASE_ITEMS  = 24;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [WVAL_W-1:0] START_WEIGHTS [WEIGHT_COUNT] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 32'h0000_0000, 32'hFF00_0000,
        32'h0080_0000, 32'h0100_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0200_0000,
        32'hFE00_0000, 32'h0040_0000, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000
    };

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [WIDX_W-1:0]         widx;
        logic signed [WVAL_W-1:0]  wval;
    } request_t;

    typedef struct {
        logic [CTRL_W-1:0]         idx;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      last;
    } control_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [FUNC_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [CTRL_W-1:0]       m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    sample_ring_bezier_fit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted block state
    logic signed [COORD_W-1:0] ring_xs [RING];
    logic signed [COORD_W-1:0] ring_ys [RING];
    logic signed [WVAL_W-1:0]  weights [WEIGHT_COUNT];
    logic [SLOT_W-1:0]         newest_slot = '0;
    logic                      ring_empty = 1'b1;
    logic [1:0]                still_count = '0;
    logic [STRIDE_W-1:0]       stride_cfg = STRIDE_RESET;
    logic [THR_W-1:0]          thresh_cfg = THRESH_RESET;

    request_t pending [$];
    control_t control_due [$];
    request_t held;
    control_t got;
    control_t want;

    int posted = 0;
    int accepted = 0;
    int predicts = 0;
    int floods = 0;
    int checked = 0;
    int errors = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_wait = 0;
    int send_gap_max = 11;
    int recv_stall_max = 11;
    int border_step = 0;
    logic take_next;
    logic signed [COORD_W-1:0] trail_x = '0;
    logic signed [COORD_W-1:0] trail_y = '0;

    task automatic enqueue_point(input logic signed [COORD_W-1:0] px,
                                 input logic signed [COORD_W-1:0] py);
        logic signed [COORD_W:0] ddx;
        logic signed [COORD_W:0] ddy;
        logic [COORD_W:0]        adx;
        logic [COORD_W:0]        ady;
        logic [63:0]             dist_sq;
        logic                    moved;
        if (ring_empty)
        begin
            newest_slot = '0;
            ring_empty  = 1'b0;
            still_count = STILL_MAX;
        end
        else
        begin
            ddx = ring_xs[newest_slot] - px;
            ddy = ring_ys[newest_slot] - py;
            adx = (ddx < 0) ? -ddx : ddx;
            ady = (ddy < 0) ? -ddy : ddy;
            // a step of a whole unit on either axis always counts as movement
            moved = (adx >= 33'h1_0000) || (ady >= 33'h1_0000);
            if (!moved)
            begin
                dist_sq = 64'(adx) * 64'(adx) + 64'(ady) * 64'(ady);
                moved = dist_sq > {32'b0, thresh_cfg};
            end
            if (moved)
                still_count = '0;
            else if (still_count != STILL_MAX)
                still_count = still_count + 2'd1;
            newest_slot = newest_slot + 1'b1;
        end
        if (still_count == STILL_MAX)
        begin
            floods++;
            for (int i = 0; i < RING; i++)
            begin
                ring_xs[i] = px;
                ring_ys[i] = py;
            end
        end
        else
        begin
            ring_xs[newest_slot] = px;
            ring_ys[newest_slot] = py;
        end
    endtask

    function automatic logic signed [COORD_W-1:0] clamp_q16(input logic signed [65:0] acc);
        logic signed [65:0] s;
        s = acc >>> FRAC_SHIFT;
        if (s > 66'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (s < -66'sh8000_0000)
            return 32'sh8000_0000;
        return s[COORD_W-1:0];
    endfunction

    task automatic fit_controls();
        logic [SLOT_W-1:0]  slot [TAP_COUNT];
        logic signed [65:0] acc_x;
        logic signed [65:0] acc_y;
        control_t           c;
        for (int i = 0; i < TAP_COUNT; i++)
            slot[i] = newest_slot - SLOT_W'((HALF_DEGREE - i) * stride_cfg);
        for (int k = 0; k < CONTROL_COUNT; k++)
        begin
            acc_x = '0;
            acc_y = '0;
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                acc_x = acc_x + weights[k * TAP_COUNT + i] * ring_xs[slot[i]];
                acc_y = acc_y + weights[k * TAP_COUNT + i] * ring_ys[slot[i]];
            end
            c.idx  = CTRL_W'(k);
            c.cx   = clamp_q16(acc_x);
            c.cy   = clamp_q16(acc_y);
            c.last = (k == CONTROL_COUNT - 1);
            control_due.push_back(c);
        end
        predicts++;
    endtask

    task automatic apply_request(input request_t r);
        case (r.func)
            FUNC_ENQ:  enqueue_point(r.x, r.y);
            FUNC_PRED: fit_controls();
            FUNC_WGT:
                if (r.widx < WEIGHT_COUNT)
                    weights[r.widx] = r.wval;
            default: ;
        endcase
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            take_next = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(held);
                accepted++;
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    held = pending.pop_front();
                    s_axis_tdata  <= IN_TDATA_W'({held.wval, held.widx, held.y, held.x});
                    s_axis_tuser  <= held.func;
                    s_axis_tvalid <= 1'b1;
                    send_gap = $urandom_range(0, send_gap_max);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.cx   = m_axis_tdata[COORD_W-1:0];
                got.cy   = m_axis_tdata[2*COORD_W-1:COORD_W];
                got.idx  = m_axis_tuser;
                got.last = m_axis_tlast;
                if (control_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected control point: expected none,", $time,
                             " got idx %0d x %h y %h last %b",
                             got.idx, got.cx, got.cy, got.last);
                end
                else
                begin
                    want = control_due.pop_front();
                    checked++;
                    if (got.idx !== want.idx || got.cx !== want.cx || got.cy !== want.cy ||
                        got.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: control point mismatch: expected idx %0d x %h y %h last %b,",
                                 $time, want.idx, want.cx, want.cy, want.last,
                                 " got idx %0d x %h y %h last %b",
                                 got.idx, got.cx, got.cy, got.last);
                    end
                end
                recv_wait = $urandom_range(0, recv_stall_max);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("%0t: timeout with %0d control points outstanding", $time,
                     control_due.size());
            $display("sample_ring_bezier_fit_test: FAIL");
            $finish;
        end
    end

    task automatic post(input logic [FUNC_W-1:0] f, input logic [COORD_W-1:0] px,
                        input logic [COORD_W-1:0] py, input logic [WIDX_W-1:0] wi,
                        input logic [WVAL_W-1:0] wv);
        request_t r;
        r.func = f;
        r.x    = px;
        r.y    = py;
        r.widx = wi;
        r.wval = wv;
        pending.push_back(r);
        posted++;
    endtask

    task automatic settle();
        while (accepted != posted || control_due.size() != 0)
            @(posedge clk);
        // let a ring flood still in progress finish
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_STRIDE)
            stride_cfg = val[STRIDE_W-1:0];
        else
            thresh_cfg = val;
    endtask

    function automatic logic signed [COORD_W-1:0] near_step();
        logic signed [COORD_W-1:0] mag;
        case ($urandom_range(0, 5))
            0:       mag = '0;
            1:       mag = border_step;
            2:       mag = border_step + 1;
            3:       mag = $urandom_range(0, 255);
            4:       mag = $urandom_range(0, 65535);
            default: mag = 32'sh1_0000;
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic signed [COORD_W-1:0] any_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            3:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            // within +/-1000.0 so that fits mostly stay in range
            default: return 32'($urandom_range(0, 131072000)) - 32'd65536000;
        endcase
    endfunction

    function automatic logic signed [WVAL_W-1:0] any_weight();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endfunction

    task automatic queue_random(input int quota);
        int made;
        int pick;
        logic [WIDX_W-1:0] wi;
        made = 0;
        while (made < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // drift around the last point to build up and break stillness
                repeat ($urandom_range(1, 6))
                begin
                    trail_x = trail_x + near_step();
                    if ($urandom_range(0, 1))
                        trail_y = trail_y + near_step();
                    post(FUNC_ENQ, trail_x, trail_y, WIDX_W'($urandom), $urandom);
                    made++;
                end
            end
            else if (pick < 65)
            begin
                trail_x = any_coord();
                trail_y = any_coord();
                post(FUNC_ENQ, trail_x, trail_y, WIDX_W'($urandom), $urandom);
                made++;
            end
            else if (pick < 85)
            begin
                post(FUNC_PRED, $urandom, $urandom, WIDX_W'($urandom), $urandom);
                made++;
            end
            else if (pick < 93)
            begin
                wi = WIDX_W'($urandom_range(0, WEIGHT_COUNT));
                post(FUNC_WGT, $urandom, $urandom, wi, any_weight());
                if (wi < WEIGHT_COUNT)
                    made++;
            end
            else
                post(FUNC_UNUSED, $urandom, $urandom, WIDX_W'($urandom), $urandom);
        end
    endtask

    task automatic run_phase(input logic [31:0] stride, input logic [31:0] thr, input int step,
                             input int gap_max, input int stall_max);
        write_register(CFG_STRIDE, stride);
        write_register(CFG_THRESH, thr);
        border_step    = step;
        send_gap_max   = gap_max;
        recv_stall_max = stall_max;
        queue_random(PHASE_ITEMS);
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset configuration; first sample floods the ring
        post(FUNC_ENQ, 32'h7FFF_FFFF, 32'h8000_0000, 4'hF, 32'hFFFF_FFFF);
        for (int i = 0; i < WEIGHT_COUNT; i++)
            post(FUNC_WGT, 32'h0, 32'hFFFF_FFFF, WIDX_W'(i), START_WEIGHTS[i]);
        post(FUNC_WGT, 32'h0, 32'h0, WIDX_W'(WEIGHT_COUNT), 32'h1234_5678);
        post(FUNC_UNUSED, 32'hFFFF_FFFF, 32'h0, 4'hF, 32'h0);
        post(FUNC_PRED, 32'h0, 32'h0, 4'h0, 32'h0);
        post(FUNC_ENQ, 32'h8000_0000, 32'h7FFF_FFFF, 4'h0, 32'h0);
        post(FUNC_ENQ, 32'h0, 32'h0, 4'h0, 32'h0);
        post(FUNC_ENQ, 32'h0000_0400, 32'h0, 4'h0, 32'h0);
        // squared step lands just under the reset threshold
        post(FUNC_ENQ, 32'h0000_0400, 32'h0000_0818, 4'h0, 32'h0);
        post(FUNC_ENQ, 32'h0000_0400, 32'h0000_0818, 4'h0, 32'h0);
        post(FUNC_PRED, 32'h0, 32'h0, 4'h0, 32'h0);
        trail_x = 32'h0000_0400;
        trail_y = 32'h0000_0818;
        settle();

        run_phase(32'd0, 32'h0, 0, 0, 0);
        run_phase(32'd31, 32'hFFFF_FFFF, 65535, 11, 0);
        run_phase(32'd2, 32'd160000, 400, 0, 11);
        run_phase(32'($urandom_range(1, 31)), $urandom, 0, 11, 11);
        run_phase(32'd1, 32'd4294967, 2072, 11, 11);

        $display("Covered %0d requests, %0d predicts, %0d ring floods, %0d points checked",
                 accepted, predicts, floods, checked);
        $display("over strides 0 to 31, thresholds 0 to full scale, with and without stalls");
        if (errors == 0)
            $display("sample_ring_bezier_fit_test: PASS");
        else
            $display("sample_ring_bezier_fit_test: FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/sbf_pkg.sv
design/sbf_dp.sv
design/sbf_ctrl.sv
design/sample_ring_bezier_fit.sv
design/sbf_chk.sv
tb/sample_ring_bezier_fit_test.sv
